/* design/tta_pkg.sv */
// Shared types, codes and constants for the tick timer and alarm bank.
package tta_pkg;

    localparam int NUM_TIMERS_DEF  = 8;
    localparam int NUM_ALARMS_DEF  = 8;
    localparam int NUM_TOPICS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int FUNC_W     = 3;
    localparam int CH_W       = 3;
    localparam int TOPIC_W    = 3;
    localparam int LOAD_W     = 32;
    localparam int TICK_W     = 32;
    localparam int MAP_W      = 8;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK     = 3'd0,
        FN_T_START  = 3'd1,
        FN_T_STOP   = 3'd2,
        FN_A_START  = 3'd3,
        FN_A_STOP   = 3'd4,
        FN_SERVICE  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        logic tick_sched;
        logic sweep_last;
    } dp_status_t;

endpackage

/* design/tta_ctrl.sv */
// Controller state machine: sequences capture, execute, sweep and report.
module tta_ctrl
    import tta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.tick_sched ? ST_SWEEP : ST_REPORT;
            end
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.step    = (state_reg == ST_SWEEP);
        cmd.report  = (state_reg == ST_REPORT) && out_free;
        if (cmd.report)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

/* design/tta_dp.sv */
// Datapath: channel tables, status bitmaps, tick counter and result register.
module tta_dp
    import tta_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int NUM_ALARMS  = NUM_ALARMS_DEF,
    parameter int NUM_TOPICS  = NUM_TOPICS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]    s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t              cmd,
    output dp_status_t           status
);

    localparam int SWEEP_LEN = (NUM_TIMERS > NUM_ALARMS) ? NUM_TIMERS : NUM_ALARMS;
    localparam int IDX_W     = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
    localparam int TPAD_W    = (NUM_TOPICS > MAP_W) ? NUM_TOPICS : MAP_W;
    localparam int APAD_W    = (NUM_ALARMS > MAP_W) ? NUM_ALARMS : MAP_W;

    // captured item
    func_t                  func_reg;
    logic [CH_W-1:0]        ch_reg;
    logic [COUNT_WIDTH-1:0] load_reg;
    logic [TOPIC_W-1:0]     topic_reg;

    logic                   sched_en_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [IDX_W-1:0]       idx_reg;

    logic [COUNT_WIDTH-1:0] t_rem_reg [SWEEP_LEN];
    logic [COUNT_WIDTH-1:0] t_rld_reg [SWEEP_LEN];
    logic [TOPIC_W-1:0]     t_map_reg [SWEEP_LEN];
    logic [COUNT_WIDTH-1:0] a_rem_reg [SWEEP_LEN];

    logic [NUM_TIMERS-1:0]  t_act_reg;
    logic [NUM_ALARMS-1:0]  a_act_reg;
    logic [NUM_TOPICS-1:0]  pend_reg;
    logic [NUM_ALARMS-1:0]  fired_reg;

    logic [M_TDATA_W-1:0]   out_data_reg;

    logic [SWEEP_LEN-1:0]   t_act_pad;
    logic [SWEEP_LEN-1:0]   a_act_pad;
    logic [SWEEP_LEN-1:0]   fired_pad;
    logic [TPAD_W-1:0]      pend_out_pad;
    logic [APAD_W-1:0]      fired_out_pad;

    logic                   t_go;
    logic                   t_hit;
    logic [COUNT_WIDTH-1:0] t_dec;
    logic [TOPIC_W-1:0]     t_map;
    logic                   a_go;
    logic                   a_hit;
    logic [COUNT_WIDTH-1:0] a_dec;
    logic                   t_ch_ok;
    logic                   a_ch_ok;
    logic                   is_service;

    assign t_act_pad = SWEEP_LEN'(t_act_reg);
    assign a_act_pad = SWEEP_LEN'(a_act_reg);
    assign fired_pad = SWEEP_LEN'(fired_reg);

    assign pend_out_pad  = TPAD_W'(pend_reg);
    assign fired_out_pad = APAD_W'(fired_reg);

    assign t_ch_ok    = int'(ch_reg) < NUM_TIMERS;
    assign a_ch_ok    = int'(ch_reg) < NUM_ALARMS;
    assign is_service = (func_reg == FN_SERVICE);

    // one timer and one alarm channel per sweep cycle
    always_comb
    begin
        t_go  = t_act_pad[idx_reg];
        t_dec = t_rem_reg[idx_reg] - COUNT_WIDTH'(1);
        t_hit = (t_dec == '0);
        t_map = t_map_reg[idx_reg];
        a_go  = a_act_pad[idx_reg] && !fired_pad[idx_reg];
        a_dec = a_rem_reg[idx_reg] - COUNT_WIDTH'(1);
        a_hit = (a_dec == '0);
    end

    assign status.tick_sched = (func_reg == FN_TICK) && sched_en_reg;
    assign status.sweep_last = (idx_reg == IDX_W'(SWEEP_LEN - 1));

    // payload: captured item, channel tables, result word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func_t'(s_tuser);
            ch_reg    <= s_tdata[CH_W-1:0];
            load_reg  <= COUNT_WIDTH'(s_tdata[CH_W +: LOAD_W]);
            topic_reg <= s_tdata[CH_W+LOAD_W +: TOPIC_W];
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < SWEEP_LEN; i++)
            begin
                if (int'(ch_reg) == i)
                begin
                    if (func_reg == FN_T_START && t_ch_ok)
                    begin
                        t_rem_reg[i] <= load_reg;
                        t_rld_reg[i] <= load_reg;
                        t_map_reg[i] <= topic_reg;
                    end
                    if (func_reg == FN_A_START && a_ch_ok)
                    begin
                        a_rem_reg[i] <= load_reg;
                    end
                end
            end
        end
        if (cmd.step)
        begin
            if (t_go)
            begin
                t_rem_reg[idx_reg] <= t_hit ? t_rld_reg[idx_reg] : t_dec;
            end
            if (a_go)
            begin
                a_rem_reg[idx_reg] <= a_dec;
            end
        end
        if (cmd.report)
        begin
            out_data_reg <= {fired_out_pad[MAP_W-1:0], pend_out_pad[MAP_W-1:0], tick_reg};
        end
    end

    // control state: enable, counter, sweep index, bitmaps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_en_reg <= 1'b0;
            tick_reg     <= '0;
            idx_reg      <= '0;
            t_act_reg    <= '0;
            a_act_reg    <= '0;
            pend_reg     <= '0;
            fired_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sched_en_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                idx_reg <= '0;
                case (func_reg)
                    FN_TICK:
                    begin
                        tick_reg <= tick_reg + TICK_W'(1);
                    end
                    FN_T_START, FN_T_STOP:
                    begin
                        for (int i = 0; i < NUM_TIMERS; i++)
                        begin
                            if (int'(ch_reg) == i)
                            begin
                                t_act_reg[i] <= (func_reg == FN_T_START);
                            end
                        end
                    end
                    FN_A_START:
                    begin
                        for (int i = 0; i < NUM_ALARMS; i++)
                        begin
                            if (int'(ch_reg) == i)
                            begin
                                a_act_reg[i] <= 1'b1;
                            end
                        end
                    end
                    FN_A_STOP:
                    begin
                        for (int i = 0; i < NUM_ALARMS; i++)
                        begin
                            if (int'(ch_reg) == i)
                            begin
                                a_act_reg[i] <= 1'b0;
                                fired_reg[i] <= 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                idx_reg <= status.sweep_last ? '0 : idx_reg + IDX_W'(1);
                for (int t = 0; t < NUM_TOPICS; t++)
                begin
                    if (t_go && t_hit && int'(t_map) == t)
                    begin
                        pend_reg[t] <= 1'b1;
                    end
                end
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (a_go && a_hit && int'(idx_reg) == i)
                    begin
                        fired_reg[i] <= 1'b1;
                    end
                end
            end
            // service: report first, then retire fired alarms and clear flags
            if (cmd.report && is_service)
            begin
                a_act_reg <= a_act_reg & ~fired_reg;
                fired_reg <= '0;
                pend_reg  <= '0;
            end
        end
    end

    assign m_tdata = out_data_reg;

endmodule

/* design/tick_timer_alarm_bank.sv */
// Top level of the tick timer and alarm bank: controller plus datapath.
//
// Usage:
//   Input channel (s_*): one transfer per command. s_tuser carries the
//   command code (tick, timer start/stop, alarm start/stop, service);
//   s_tdata carries channel, load value and topic.
//   Output channel (m_*): exactly one result transfer per command, with the
//   tick counter and the pending-topic and fired-alarm bitmaps.
//   Configuration: cfg_wr_en/cfg_wr_data write the schedule enable bit;
//   write it only while no command is in flight.
// Sequencing:
//   A command is captured, executed in the next cycle and its result is
//   loaded into the output register in the report step once it is free.
//   A tick with scheduling enabled also sweeps the channel tables, one
//   timer and one alarm channel per cycle through a single decrement unit
//   each. A new command is taken only after the last one has reported.
// Reset clears the counter, all active, pending and fired bits, and the
// schedule enable. When the receiver stalls, the result holds in the output
// register while the next command is taken and worked; that command then
// waits at its report step until the register frees up.
module tick_timer_alarm_bank
    import tta_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int NUM_ALARMS  = NUM_ALARMS_DEF,
    parameter int NUM_TOPICS  = NUM_TOPICS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,  // schedule_enable
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] channel_index, [34:3] load_value, [37:35] topic_index, [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  logic [FUNC_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] tick_now, [39:32] topics_pending, [47:40] alarms_fired
    output logic [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequence each command: capture, execute, optional sweep, report
    tta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold channel tables and bitmaps, advance counts during the sweep
    tta_dp #(
        .NUM_TIMERS  (NUM_TIMERS),
        .NUM_ALARMS  (NUM_ALARMS),
        .NUM_TOPICS  (NUM_TOPICS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
